>>> hw/rtl/xbg_pkg.sv
// shared types, codes and constants for the xoshiro256++ byte generator
package xbg_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned NWORDS    = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned STEP_W    = 8;

  localparam int unsigned ROT_OUT = 23;
  localparam int unsigned SHIFT_T = 17;
  localparam int unsigned ROT_S3  = 45;

  localparam logic [255:0] JUMP_POLY = {
    64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
    64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
  };

  localparam logic [WORD_W-1:0] SEED0_RST = 64'd1;
  localparam logic [WORD_W-1:0] SEED1_RST = 64'd0;
  localparam logic [WORD_W-1:0] SEED2_RST = 64'd0;
  localparam logic [WORD_W-1:0] SEED3_RST = 64'd0;

  typedef enum logic [1:0] {
    MODE_GEN  = 2'd0,
    MODE_JUMP = 2'd1,
    MODE_LOAD = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED0 = 3'd0,
    REG_SEED1 = 3'd1,
    REG_SEED2 = 3'd2,
    REG_SEED3 = 3'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FINAL,
    ST_JUMP,
    ST_DONE
  } fsm_t;

  typedef struct packed {
    logic [WORD_W-1:0] w3;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w0;
  } gen_state_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input int unsigned r);
    rotl = (v << r) | (v >> (WORD_W - r));
  endfunction

endpackage

>>> hw/rtl/xbg_step.sv
// shared xoshiro256++ next-state unit with the output pre-sum
module xbg_step (
  input  xbg_pkg::gen_state_t         cur,
  output xbg_pkg::gen_state_t         nxt,
  output logic [xbg_pkg::WORD_W-1:0]  pre_sum
);

  logic [xbg_pkg::WORD_W-1:0] t;
  logic [xbg_pkg::WORD_W-1:0] a2;
  logic [xbg_pkg::WORD_W-1:0] a3;
  logic [xbg_pkg::WORD_W-1:0] a1;
  logic [xbg_pkg::WORD_W-1:0] a0;

  always_comb begin
    pre_sum = cur.w0 + cur.w3;
    t       = cur.w1 << xbg_pkg::SHIFT_T;
    a2      = cur.w2 ^ cur.w0;
    a3      = cur.w3 ^ cur.w1;
    a1      = cur.w1 ^ a2;
    a0      = cur.w0 ^ a3;
    nxt.w0  = a0;
    nxt.w1  = a1;
    nxt.w2  = a2 ^ t;
    nxt.w3  = xbg_pkg::rotl(a3, xbg_pkg::ROT_S3);
  end

endmodule

>>> hw/rtl/xoshiro256pp_byte_generator_unit.sv
// xoshiro256++ byte generator top level with sequencer and output register
// generate: the request passes the final and done states before the output register loads; no new request until idle
// jump: all 256 bits of the jump polynomial are applied in turn, stepping through the shared next-state unit
// load, zero count and other modes: the sequencer goes straight to its done state and loads the output register
// output stalls hold the sequencer in its done state until the output register is free
// synchronous active-low reset restores seeds and state to {1,0,0,0}
module xoshiro256pp_byte_generator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_mode,
  input  logic [xbg_pkg::CNT_W-1:0]       in_byte_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [xbg_pkg::WORD_W-1:0]      out_random_data,
  output logic [xbg_pkg::CNT_W-1:0]       out_data_bytes,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [xbg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [xbg_pkg::WORD_W-1:0]      cfg_data
);

  xbg_pkg::fsm_t      state_r, state_nxt;
  xbg_pkg::gen_state_t gen_r, gen_nxt, step_out, acc_r, acc_nxt;
  logic [xbg_pkg::WORD_W-1:0] pre_sum;
  logic [xbg_pkg::WORD_W-1:0] seed0_r, seed1_r, seed2_r, seed3_r;
  logic [xbg_pkg::WORD_W-1:0] sum_r, g0_r, res_data_r, res_data_nxt, word;
  logic [xbg_pkg::CNT_W-1:0]  cnt_r, res_bytes_r, res_bytes_nxt, cnt_sat;
  logic [xbg_pkg::STEP_W-1:0] jstep_r;
  logic [xbg_pkg::WORD_W-1:0] out_data_r;
  logic [xbg_pkg::CNT_W-1:0]  out_bytes_r;
  logic                       out_valid_r;
  logic                       in_acc, out_free, out_load, jbit, jlast;
  xbg_pkg::mode_t             mode;

  xbg_step u_step (
    .cur     (gen_r),
    .nxt     (step_out),
    .pre_sum (pre_sum)
  );

  assign mode     = xbg_pkg::mode_t'(in_mode);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign jbit     = xbg_pkg::JUMP_POLY[jstep_r];
  assign jlast    = (jstep_r == {xbg_pkg::STEP_W{1'b1}});
  assign cnt_sat  = (in_byte_count > xbg_pkg::CNT_W'(8)) ? xbg_pkg::CNT_W'(8) : in_byte_count;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      xbg_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (mode == xbg_pkg::MODE_GEN && cnt_sat != '0) state_nxt = xbg_pkg::ST_FINAL;
          else if (mode == xbg_pkg::MODE_JUMP) state_nxt = xbg_pkg::ST_JUMP;
          else state_nxt = xbg_pkg::ST_DONE;
        end
      end
      xbg_pkg::ST_FINAL: state_nxt = xbg_pkg::ST_DONE;
      xbg_pkg::ST_JUMP: begin
        if (jlast) state_nxt = xbg_pkg::ST_DONE;
      end
      xbg_pkg::ST_DONE: begin
        if (out_free) state_nxt = xbg_pkg::ST_IDLE;
      end
      default: state_nxt = xbg_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    unique case (state_r)
      xbg_pkg::ST_IDLE:  in_stall = 1'b0;
      xbg_pkg::ST_FINAL: in_stall = 1'b1;
      xbg_pkg::ST_JUMP:  in_stall = 1'b1;
      xbg_pkg::ST_DONE:  out_load = out_free;
      default:           in_stall = 1'b1;
    endcase
  end

  // datapath next values
  always_comb begin
    gen_nxt       = gen_r;
    acc_nxt       = acc_r;
    res_data_nxt  = res_data_r;
    res_bytes_nxt = res_bytes_r;
    word          = xbg_pkg::rotl(sum_r, xbg_pkg::ROT_OUT) + g0_r;
    unique case (state_r)
      xbg_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_data_nxt  = '0;
          res_bytes_nxt = '0;
          unique case (mode)
            xbg_pkg::MODE_GEN: begin
              if (cnt_sat != '0) gen_nxt = step_out;
            end
            xbg_pkg::MODE_JUMP: acc_nxt = '0;
            xbg_pkg::MODE_LOAD: begin
              gen_nxt.w0 = seed0_r;
              gen_nxt.w1 = seed1_r;
              gen_nxt.w2 = seed2_r;
              gen_nxt.w3 = seed3_r;
            end
            default: gen_nxt = gen_r;
          endcase
        end
      end
      xbg_pkg::ST_FINAL: begin
        res_bytes_nxt = cnt_r;
        unique case (cnt_r)
          4'd1:    res_data_nxt = word >> 56;
          4'd2:    res_data_nxt = word >> 48;
          4'd3:    res_data_nxt = word >> 40;
          4'd4:    res_data_nxt = word >> 32;
          4'd5:    res_data_nxt = word >> 24;
          4'd6:    res_data_nxt = word >> 16;
          4'd7:    res_data_nxt = word >> 8;
          default: res_data_nxt = word;
        endcase
      end
      xbg_pkg::ST_JUMP: begin
        if (jbit) acc_nxt = acc_r ^ gen_r;
        gen_nxt = jlast ? acc_nxt : step_out;
      end
      xbg_pkg::ST_DONE: gen_nxt = gen_r;
      default:          gen_nxt = gen_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xbg_pkg::ST_IDLE;
      gen_r.w0    <= xbg_pkg::SEED0_RST;
      gen_r.w1    <= xbg_pkg::SEED1_RST;
      gen_r.w2    <= xbg_pkg::SEED2_RST;
      gen_r.w3    <= xbg_pkg::SEED3_RST;
      acc_r       <= '0;
      jstep_r     <= '0;
      seed0_r     <= xbg_pkg::SEED0_RST;
      seed1_r     <= xbg_pkg::SEED1_RST;
      seed2_r     <= xbg_pkg::SEED2_RST;
      seed3_r     <= xbg_pkg::SEED3_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      gen_r   <= gen_nxt;
      acc_r   <= acc_nxt;
      if (state_r == xbg_pkg::ST_JUMP) jstep_r <= jstep_r + 1'b1;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          xbg_pkg::REG_SEED0: seed0_r <= cfg_data;
          xbg_pkg::REG_SEED1: seed1_r <= cfg_data;
          xbg_pkg::REG_SEED2: seed2_r <= cfg_data;
          xbg_pkg::REG_SEED3: seed3_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_data_r  <= res_data_nxt;
    res_bytes_r <= res_bytes_nxt;
    if (in_acc) begin
      sum_r <= pre_sum;
      g0_r  <= gen_r.w0;
      cnt_r <= cnt_sat;
    end
    if (out_load) begin
      out_data_r  <= res_data_r;
      out_bytes_r <= res_bytes_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_random_data = out_data_r;
  assign out_data_bytes  = out_bytes_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while sequencer busy");

  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_bytes == '0 |-> out_random_data == '0)
    else $error("zero-byte result carries data");

  a_bytes_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data_bytes <= xbg_pkg::CNT_W'(8))
    else $error("byte count above eight");

  a_jump_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != xbg_pkg::ST_JUMP |-> jstep_r == '0)
    else $error("jump counter not wrapped outside jump");
`endif

endmodule

>>> bench/tb.sv
// testbench for the xoshiro256++ byte generator checked against a local model
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0]                    MODE_UNUSED   = 2'd3;
  localparam logic [xbg_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd4;
  localparam int                            MAX_BYTES     = 8;
  localparam int                            JUMP_STEPS    = 256;
  localparam int                            CYCLE_LIMIT   = 1000000;
  localparam int                            SETTLE_CYCLES = 8;
  localparam int                            TAIL_CYCLES   = 300;

  typedef struct packed {
    logic [xbg_pkg::WORD_W-1:0] data;
    logic [xbg_pkg::CNT_W-1:0]  nbytes;
  } byte_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    in_mode = xbg_pkg::MODE_GEN;
  logic [xbg_pkg::CNT_W-1:0]     in_byte_count = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [xbg_pkg::WORD_W-1:0]    out_random_data;
  logic [xbg_pkg::CNT_W-1:0]     out_data_bytes;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [xbg_pkg::CFG_IDX_W-1:0] cfg_index = xbg_pkg::REG_SEED0;
  logic [xbg_pkg::WORD_W-1:0]    cfg_data = '0;

  logic [xbg_pkg::WORD_W-1:0] seed_regs [xbg_pkg::NWORDS];
  logic [xbg_pkg::WORD_W-1:0] gen_words [xbg_pkg::NWORDS];
  byte_result_t               pending_bytes [$];
  int                         tx_idle_pct = 0;
  int                         rx_idle_pct = 0;
  int                         error_count = 0;
  int                         cycle_count = 0;

  xoshiro256pp_byte_generator_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_byte_count   (in_byte_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_random_data (out_random_data),
    .out_data_bytes  (out_data_bytes),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [xbg_pkg::WORD_W-1:0] rot64(input logic [xbg_pkg::WORD_W-1:0] v,
                                                       input int r);
    return (v << r) | (v >> (xbg_pkg::WORD_W - r));
  endfunction

  task automatic advance_state(output logic [xbg_pkg::WORD_W-1:0] word);
    logic [xbg_pkg::WORD_W-1:0] t;
    word = rot64(gen_words[0] + gen_words[3], xbg_pkg::ROT_OUT) + gen_words[0];
    t = gen_words[1] << xbg_pkg::SHIFT_T;
    gen_words[2] ^= gen_words[0];
    gen_words[3] ^= gen_words[1];
    gen_words[1] ^= gen_words[2];
    gen_words[0] ^= gen_words[3];
    gen_words[2] ^= t;
    gen_words[3] = rot64(gen_words[3], xbg_pkg::ROT_S3);
  endtask

  task automatic jump_state();
    logic [xbg_pkg::WORD_W-1:0] acc [xbg_pkg::NWORDS];
    logic [xbg_pkg::WORD_W-1:0] discard;
    for (int k = 0; k < xbg_pkg::NWORDS; k++) acc[k] = '0;
    for (int n = 0; n < JUMP_STEPS; n++) begin
      if (xbg_pkg::JUMP_POLY[n]) begin
        for (int k = 0; k < xbg_pkg::NWORDS; k++) acc[k] ^= gen_words[k];
      end
      advance_state(discard);
    end
    for (int k = 0; k < xbg_pkg::NWORDS; k++) gen_words[k] = acc[k];
  endtask

  task automatic predict_bytes(input logic [1:0] mode,
                               input logic [xbg_pkg::CNT_W-1:0] cnt,
                               output byte_result_t r);
    logic [xbg_pkg::WORD_W-1:0] w;
    int c;
    r = '0;
    case (mode)
      xbg_pkg::MODE_GEN: begin
        c = (int'(cnt) > MAX_BYTES) ? MAX_BYTES : int'(cnt);
        if (c != 0) begin
          advance_state(w);
          r.data = w >> (8 * (MAX_BYTES - c));
          r.nbytes = xbg_pkg::CNT_W'(c);
        end
      end
      xbg_pkg::MODE_JUMP: jump_state();
      xbg_pkg::MODE_LOAD: begin
        for (int k = 0; k < xbg_pkg::NWORDS; k++) gen_words[k] = seed_regs[k];
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [xbg_pkg::WORD_W-1:0] want,
                                 input logic [xbg_pkg::WORD_W-1:0] got);
    $display("mismatch at cycle %0d, %s: expected %h got %h", cycle_count, what, want, got);
    error_count++;
  endtask

  task automatic check_result();
    byte_result_t e;
    if (pending_bytes.size() == 0) begin
      report_mismatch("result with no request", '0, out_random_data);
    end else begin
      e = pending_bytes.pop_front();
      if (out_random_data !== e.data) report_mismatch("random_data", e.data, out_random_data);
      if (out_data_bytes !== e.nbytes) begin
        report_mismatch("data_bytes", xbg_pkg::WORD_W'(e.nbytes),
                        xbg_pkg::WORD_W'(out_data_bytes));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [xbg_pkg::CNT_W-1:0] cnt);
    byte_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_byte_count <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_bytes(mode, cnt, r);
    pending_bytes.push_back(r);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [xbg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [xbg_pkg::WORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (int'(idx) < xbg_pkg::NWORDS) seed_regs[idx[1:0]] = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_seeds(input logic [xbg_pkg::WORD_W-1:0] s0,
                             input logic [xbg_pkg::WORD_W-1:0] s1,
                             input logic [xbg_pkg::WORD_W-1:0] s2,
                             input logic [xbg_pkg::WORD_W-1:0] s3);
    wait_idle();
    write_reg(xbg_pkg::REG_SEED0, s0);
    write_reg(xbg_pkg::REG_SEED1, s1);
    write_reg(xbg_pkg::REG_SEED2, s2);
    write_reg(xbg_pkg::REG_SEED3, s3);
  endtask

  function automatic logic [xbg_pkg::WORD_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_reset_sequence();
    for (int c = 1; c <= MAX_BYTES; c++) send_item(xbg_pkg::MODE_GEN, xbg_pkg::CNT_W'(c));
  endtask

  task automatic test_count_limits();
    send_item(xbg_pkg::MODE_GEN, '0);
    send_item(xbg_pkg::MODE_GEN, xbg_pkg::CNT_W'(9));
    send_item(xbg_pkg::MODE_GEN, '1);
  endtask

  task automatic test_unused_mode();
    send_item(MODE_UNUSED, '0);
    send_item(MODE_UNUSED, '1);
  endtask

  task automatic test_jump_ahead();
    send_item(xbg_pkg::MODE_JUMP, xbg_pkg::CNT_W'(MAX_BYTES));
    send_item(xbg_pkg::MODE_GEN, xbg_pkg::CNT_W'(MAX_BYTES));
    send_item(xbg_pkg::MODE_JUMP, '1);
    send_item(xbg_pkg::MODE_GEN, xbg_pkg::CNT_W'(1));
  endtask

  task automatic test_seed_extremes();
    write_seeds('1, '1, '1, '1);
    send_item(xbg_pkg::MODE_LOAD, '0);
    send_item(xbg_pkg::MODE_GEN, xbg_pkg::CNT_W'(MAX_BYTES));
    write_seeds('0, '0, '0, '0);
    send_item(xbg_pkg::MODE_LOAD, '1);
    send_item(xbg_pkg::MODE_GEN, xbg_pkg::CNT_W'(MAX_BYTES));
    send_item(xbg_pkg::MODE_JUMP, '0);
    send_item(xbg_pkg::MODE_GEN, xbg_pkg::CNT_W'(3));
  endtask

  task automatic test_unused_index();
    write_seeds(rand64(), rand64(), rand64(), rand64());
    for (int k = 0; k < xbg_pkg::NWORDS; k++) begin
      write_reg(REG_UNUSED_LO + xbg_pkg::CFG_IDX_W'(k), rand64());
    end
    send_item(xbg_pkg::MODE_LOAD, '0);
    send_item(xbg_pkg::MODE_GEN, xbg_pkg::CNT_W'(MAX_BYTES));
  endtask

  task automatic test_drain_pause();
    send_item(xbg_pkg::MODE_GEN, xbg_pkg::CNT_W'(5));
    wait_idle();
    send_item(xbg_pkg::MODE_GEN, xbg_pkg::CNT_W'(2));
  endtask

  task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
    int pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    write_seeds(rand64(), rand64(), rand64(), rand64());
    write_reg(REG_UNUSED_LO + xbg_pkg::CFG_IDX_W'($urandom_range(3)), rand64());
    send_item(xbg_pkg::MODE_LOAD, xbg_pkg::CNT_W'($urandom_range(15)));
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(999);
      if (pick < 20) send_item(xbg_pkg::MODE_JUMP, xbg_pkg::CNT_W'($urandom_range(15)));
      else if (pick < 50) send_item(xbg_pkg::MODE_LOAD, xbg_pkg::CNT_W'($urandom_range(15)));
      else if (pick < 65) send_item(MODE_UNUSED, xbg_pkg::CNT_W'($urandom_range(15)));
      else if (pick < 200) send_item(xbg_pkg::MODE_GEN, xbg_pkg::CNT_W'($urandom_range(15)));
      else send_item(xbg_pkg::MODE_GEN, xbg_pkg::CNT_W'($urandom_range(MAX_BYTES, 1)));
      if ($urandom_range(199) == 0) wait_idle();
    end
  endtask

  initial begin
    seed_regs[0] = xbg_pkg::SEED0_RST;
    seed_regs[1] = xbg_pkg::SEED1_RST;
    seed_regs[2] = xbg_pkg::SEED2_RST;
    seed_regs[3] = xbg_pkg::SEED3_RST;
    for (int k = 0; k < xbg_pkg::NWORDS; k++) gen_words[k] = seed_regs[k];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 14;
    rx_idle_pct = 45;
    test_reset_sequence();
    test_count_limits();
    test_unused_mode();
    test_jump_ahead();
    test_seed_extremes();
    test_unused_index();
    test_drain_pause();

    test_random_traffic(340, 14, 45);
    test_random_traffic(340, 45, 14);
    test_random_traffic(340, 0, 0);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
